### rtl/vvfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvfc_pkg
// Shared constants, types and helpers of the voxel visible-face cull block.
// ----------------------------------------------------------------------------
package vvfc_pkg;

   localparam int GRID_X = 64;
   localparam int GRID_Y = 64;
   localparam int GRID_Z = 64;

   localparam int POS_W   = 6;
   localparam int VAL_W   = 8;
   localparam int MASK_W  = 6;
   // internal coordinates carry one extra bit so that pos + 1 never wraps
   localparam int CRD_W   = POS_W + 1;

   localparam int VOX_COUNT = GRID_X * GRID_Y * GRID_Z;
   localparam int ADDR_W    = $clog2(VOX_COUNT);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // read / compare slots of a query
   localparam logic [2:0] SLOT_CENTER = 3'd0;
   localparam logic [2:0] SLOT_MX     = 3'd1;
   localparam logic [2:0] SLOT_MY     = 3'd2;
   localparam logic [2:0] SLOT_MZ     = 3'd3;
   localparam logic [2:0] SLOT_PX     = 3'd4;
   localparam logic [2:0] SLOT_PY     = 3'd5;
   localparam logic [2:0] SLOT_PZ     = 3'd6;

   typedef struct packed {
      logic       load_req;
      logic       clr_we;
      logic       vox_we;
      logic       mem_re;
      logic [2:0] rd_slot;
      logic       cmp_en;
      logic [2:0] cmp_slot;
      logic       rsp_load;
   } vvfc_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic rsp_free;
   } vvfc_status_type;

   function automatic logic [ADDR_W-1:0] vox_addr(input logic [CRD_W-1:0] x,
                                                  input logic [CRD_W-1:0] y,
                                                  input logic [CRD_W-1:0] z);
      logic [31:0] t;
      t = (32'(x) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_Z) + 32'(z);
      return t[ADDR_W-1:0];
   endfunction

endpackage

### rtl/vvfc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvfc_ctrl
// Sequencer: clearing sweep, write, seven-read query, response hand-off.
// ----------------------------------------------------------------------------
module vvfc_ctrl
   import vvfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_cmd,
   output logic            req_ready,
   input  vvfc_status_type status,
   output vvfc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_CMP,
      ST_RESP
   } state_type;

   state_type  state_ff;
   logic [2:0] step_ff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_we = 1'b1;
         ST_IDLE:  cmd.load_req = req_valid;
         ST_WRITE: cmd.vox_we = 1'b1;
         ST_READ: begin
            cmd.mem_re   = 1'b1;
            cmd.rd_slot  = step_ff;
            cmd.cmp_en   = (step_ff != SLOT_CENTER);
            cmd.cmp_slot = step_ff - 3'd1;
         end
         ST_CMP: begin
            cmd.cmp_en   = 1'b1;
            cmd.cmp_slot = SLOT_PZ;
         end
         ST_RESP:  cmd.rsp_load = status.rsp_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clr_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               step_ff <= SLOT_CENTER;
               if (req_valid) begin
                  state_ff <= (req_cmd == CMD_QUERY) ? ST_READ : ST_WRITE;
               end
            end
            ST_WRITE: state_ff <= ST_IDLE;
            ST_READ: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == SLOT_PZ) state_ff <= ST_CMP;
            end
            ST_CMP:   state_ff <= ST_RESP;
            ST_RESP: begin
               if (status.rsp_free) state_ff <= ST_IDLE;
            end
            default:  state_ff <= ST_CLEAR;
         endcase
      end
   end

endmodule

### rtl/vvfc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vvfc_datapath
// Voxel store, address generation, neighbor compare and response register.
// ----------------------------------------------------------------------------
module vvfc_datapath
   import vvfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  vvfc_cmd_type      cmd,
   output vvfc_status_type   status,
   input  logic [POS_W-1:0]  req_pos_x,
   input  logic [POS_W-1:0]  req_pos_y,
   input  logic [POS_W-1:0]  req_pos_z,
   input  logic [VAL_W-1:0]  req_voxel_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [MASK_W-1:0] rsp_face_mask,
   output logic [VAL_W-1:0]  rsp_stored_value
);

   logic [VAL_W-1:0]  mem [VOX_COUNT];
   logic [VAL_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] clr_ff;

   logic [CRD_W-1:0]  x_ff, y_ff, z_ff;
   logic [VAL_W-1:0]  val_ff;
   logic              in_grid;

   logic [VAL_W-1:0]  center_ff;
   logic [MASK_W-1:0] mask_ff;

   logic              rsp_valid_ff;
   logic [MASK_W-1:0] rsp_mask_ff;
   logic [VAL_W-1:0]  rsp_val_ff;

   logic [CRD_W-1:0]  nx, ny, nz;
   logic [ADDR_W-1:0] vox_a, mem_a;
   logic              mem_we;
   logic [VAL_W-1:0]  mem_wd;
   logic              edge_hit;

   assign in_grid = (32'(x_ff) < 32'(GRID_X)) && (32'(y_ff) < 32'(GRID_Y)) &&
                    (32'(z_ff) < 32'(GRID_Z));

   assign status.clr_last = (clr_ff == ADDR_W'(VOX_COUNT - 1));
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // neighbor coordinates; a face on the grid edge keeps the center address
   always_comb begin
      nx = x_ff;
      ny = y_ff;
      nz = z_ff;
      unique case (cmd.rd_slot)
         SLOT_MX: if (x_ff != '0) nx = x_ff - 1'b1;
         SLOT_MY: if (y_ff != '0) ny = y_ff - 1'b1;
         SLOT_MZ: if (z_ff != '0) nz = z_ff - 1'b1;
         SLOT_PX: if (32'(x_ff) + 1 < 32'(GRID_X)) nx = x_ff + 1'b1;
         SLOT_PY: if (32'(y_ff) + 1 < 32'(GRID_Y)) ny = y_ff + 1'b1;
         SLOT_PZ: if (32'(z_ff) + 1 < 32'(GRID_Z)) nz = z_ff + 1'b1;
         default: ;
      endcase
   end

   // out-of-grid items touch address zero only; their effect is masked
   assign vox_a = in_grid ? vox_addr(nx, ny, nz) : '0;

   always_comb begin
      mem_we = 1'b0;
      mem_wd = val_ff;
      mem_a  = vox_a;
      if (cmd.clr_we) begin
         mem_we = 1'b1;
         mem_wd = '0;
         mem_a  = clr_ff;
      end else if (cmd.vox_we) begin
         mem_we = in_grid;
      end
   end

   always_comb begin
      unique case (cmd.cmp_slot)
         SLOT_MX: edge_hit = (x_ff == '0);
         SLOT_MY: edge_hit = (y_ff == '0);
         SLOT_MZ: edge_hit = (z_ff == '0);
         SLOT_PX: edge_hit = (32'(x_ff) + 1 >= 32'(GRID_X));
         SLOT_PY: edge_hit = (32'(y_ff) + 1 >= 32'(GRID_Y));
         SLOT_PZ: edge_hit = (32'(z_ff) + 1 >= 32'(GRID_Z));
         default: edge_hit = 1'b0;
      endcase
   end

   // single-port store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_a] <= mem_wd;
      if (cmd.mem_re) rd_ff <= mem[mem_a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_we) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         x_ff   <= CRD_W'(req_pos_x);
         y_ff   <= CRD_W'(req_pos_y);
         z_ff   <= CRD_W'(req_pos_z);
         val_ff <= req_voxel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp_en) begin
         unique case (cmd.cmp_slot)
            SLOT_CENTER: center_ff  <= rd_ff;
            SLOT_MX:     mask_ff[0] <= edge_hit || (rd_ff != center_ff);
            SLOT_MY:     mask_ff[1] <= edge_hit || (rd_ff != center_ff);
            SLOT_MZ:     mask_ff[2] <= edge_hit || (rd_ff != center_ff);
            SLOT_PX:     mask_ff[3] <= edge_hit || (rd_ff != center_ff);
            SLOT_PY:     mask_ff[4] <= edge_hit || (rd_ff != center_ff);
            SLOT_PZ:     mask_ff[5] <= edge_hit || (rd_ff != center_ff);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_val_ff  <= in_grid ? center_ff : '0;
         rsp_mask_ff <= (in_grid && center_ff != '0) ? mask_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_face_mask    = rsp_mask_ff;
   assign rsp_stored_value = rsp_val_ff;

endmodule

### rtl/voxel_visible_face_cull_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_visible_face_cull_top
// Voxel grid store with per-voxel visible-face query.
//
// Usage:
//   req_* channel (valid/ready): req_cmd selects write (store req_voxel_value
//   at req_pos_*) or query. Writes outside the grid are dropped and produce
//   no response. A query returns one rsp_* transaction: the stored value and
//   a six-bit mask (bit0..5 = -x,-y,-z,+x,+y,+z) of visible faces; a query
//   outside the grid returns zeros.
//   Sequencing: a write goes through the write state and back to idle. A query
//   reads the center voxel and its six neighbors through the single port of
//   the voxel store, one read per cycle, then compares the last neighbor and
//   loads the response; a new request is taken only once the previous one is done.
//   The response sits in its own register: once it is loaded the block goes
//   back to accepting requests while the receiver stalls; a second query
//   waits at its final step until the response register is free.
//   Reset: the store is cleared by a sweep of one entry per cycle over all
//   GRID_X*GRID_Y*GRID_Z entries (262144 at 64^3); req_ready stays low
//   until the sweep is done.
// ----------------------------------------------------------------------------
module voxel_visible_face_cull_top
   import vvfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [POS_W-1:0]  req_pos_x,
   input  logic [POS_W-1:0]  req_pos_y,
   input  logic [POS_W-1:0]  req_pos_z,
   input  logic [VAL_W-1:0]  req_voxel_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [MASK_W-1:0] rsp_face_mask,
   output logic [VAL_W-1:0]  rsp_stored_value
);

   vvfc_cmd_type    cmd;
   vvfc_status_type status;

   // sequencer: clear sweep, write, seven reads, compare, hand-off
   vvfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // store, neighbor address/compare and response register
   vvfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_voxel_value  (req_voxel_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_face_mask    (rsp_face_mask),
      .rsp_stored_value (rsp_stored_value)
   );

endmodule
